### hw/rtl/iqc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iqc_pkg
// Shared codes, constants and Q1.15 helpers for the IQ conditioner.
// ---------------------------------------------------------------------------
package iqc_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_STREAM_RESET = 2'd1,
        ACT_RETUNE = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_SWAP_IQ = 3'd0,
        REG_INVERT_Q = 3'd1,
        REG_NCO_ENABLE = 3'd2,
        REG_NCO_STEP_COS = 3'd3,
        REG_NCO_STEP_SIN = 3'd4,
        REG_ADC_BITS = 3'd5,
        REG_DISCARD_COUNT = 3'd6,
        REG_RESERVED = 3'd7
    } reg_index_t;

    localparam logic signed [15:0] Q15_ONE = 16'sd32767;
    localparam logic signed [15:0] Q15_ZERO = 16'sd0;
    localparam logic signed [15:0] Q15_MAX = 16'sd32767;
    localparam logic signed [15:0] Q15_MIN = -16'sd32768;

    localparam logic [4:0] RST_ADC_BITS = 5'd12;
    localparam logic [23:0] RST_DISCARD_COUNT = 24'd1228800;

    // Round half up at bit 15 and saturate to 16 bits.
    function automatic logic signed [15:0] round15(input logic signed [33:0] p);
        logic signed [33:0] s;
        s = (p + 34'sd16384) >>> 15;
        if (s > 34'sd32767) begin
            round15 = Q15_MAX;
        end else if (s < -34'sd32768) begin
            round15 = Q15_MIN;
        end else begin
            round15 = s[15:0];
        end
    endfunction

    // Saturating negate.
    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        logic signed [16:0] n;
        n = -17'(v);
        if (n > 17'sd32767) begin
            neg_sat = Q15_MAX;
        end else begin
            neg_sat = n[15:0];
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/iq_conditioner_nco_mixer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iq_conditioner_nco_mixer_unit
// Converter sample alignment, I/Q swap and negate, oscillator mixing and
// post-retune block dropping.
// ---------------------------------------------------------------------------
// When the output side keeps up, the block takes one word per clock and
// delivers one result per clock; a word passes one input register and one
// result register. The rate is set by the oscillator phasor loop, whose
// complex multiply by the step, rounding and saturation
// are combinational. Stream reset and retune words, words of a dropped block and
// words with the unused action code produce no result. Configuration writes
// are accepted every cycle and should be made while the block is idle.
module iq_conditioner_nco_mixer_unit
    import iqc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    localparam int IN_TDATA_W = ((2 * SAMPLE_WIDTH + 16 + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [23:0]           cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // in_i, in_q, block_length, zero fill
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    // action, block_start
    input  wire logic [2:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_i, out_q
    output logic [31:0]                m_tdata
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = SAMPLE_WIDTH + 17;

    logic             swap_iq_reg;
    logic             invert_q_reg;
    logic             nco_enable_reg;
    logic signed [15:0] step_cos_reg;
    logic signed [15:0] step_sin_reg;
    logic [4:0]       adc_bits_reg;
    logic [23:0]      discard_count_reg;

    logic             s1_valid_reg;
    action_t          s1_action_reg;
    logic signed [SW-1:0] s1_i_reg;
    logic signed [SW-1:0] s1_q_reg;
    logic             s1_start_reg;
    logic [15:0]      s1_len_reg;

    logic signed [15:0] phase_re_reg, phase_re_next;
    logic signed [15:0] phase_im_reg, phase_im_next;
    logic [23:0]      discard_left_reg, discard_left_next;
    logic             dropping_reg, dropping_next;

    logic             out_valid_reg;
    logic signed [15:0] out_i_reg, out_i_next;
    logic signed [15:0] out_q_reg, out_q_next;
    logic             result_next;

    logic             advance;
    logic             s_accept;

    logic signed [15:0] ai, aq, si, sq, sq_inv;
    logic signed [31:0] p_ir, p_qi, p_ii, p_qr;
    logic signed [31:0] p_rc, p_is, p_rs, p_ic;

    function automatic logic signed [15:0] align_sample(
        input logic signed [SW-1:0] x,
        input logic [4:0] bits
    );
        logic [4:0] b;
        logic [4:0] sh;
        logic signed [AW-1:0] ext;
        logic signed [AW-1:0] rnd;
        logic signed [AW-1:0] val;
        b = (bits == 5'd0) ? 5'd1 : bits;
        ext = AW'(x);
        if (b <= 5'd16) begin
            sh = 5'd16 - b;
            rnd = '0;
            val = ext <<< sh;
        end else begin
            sh = b - 5'd16;
            rnd = AW'(1) <<< (sh - 5'd1);
            val = (ext + rnd) >>> sh;
        end
        if (val > AW'(32767)) begin
            align_sample = Q15_MAX;
        end else if (val < -AW'(32768)) begin
            align_sample = Q15_MIN;
        end else begin
            align_sample = val[15:0];
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {out_q_reg, out_i_reg};

    always_comb
    begin
        ai = align_sample(s1_i_reg, adc_bits_reg);
        aq = align_sample(s1_q_reg, adc_bits_reg);
        si = swap_iq_reg ? aq : ai;
        sq = swap_iq_reg ? ai : aq;
        sq_inv = invert_q_reg ? neg_sat(sq) : sq;

        p_ir = 32'(si) * 32'(phase_re_reg);
        p_qi = 32'(sq_inv) * 32'(phase_im_reg);
        p_ii = 32'(si) * 32'(phase_im_reg);
        p_qr = 32'(sq_inv) * 32'(phase_re_reg);
        p_rc = 32'(phase_re_reg) * 32'(step_cos_reg);
        p_is = 32'(phase_im_reg) * 32'(step_sin_reg);
        p_rs = 32'(phase_re_reg) * 32'(step_sin_reg);
        p_ic = 32'(phase_im_reg) * 32'(step_cos_reg);

        phase_re_next = phase_re_reg;
        phase_im_next = phase_im_reg;
        discard_left_next = discard_left_reg;
        dropping_next = dropping_reg;
        result_next = 1'b0;
        out_i_next = si;
        out_q_next = sq_inv;

        case (s1_action_reg)
            ACT_STREAM_RESET:
            begin
                discard_left_next = '0;
                dropping_next = 1'b0;
                phase_re_next = Q15_ONE;
                phase_im_next = Q15_ZERO;
            end
            ACT_RETUNE:
            begin
                discard_left_next = discard_count_reg;
                phase_re_next = Q15_ONE;
                phase_im_next = Q15_ZERO;
            end
            ACT_SAMPLE:
            begin
                if (s1_start_reg) begin
                    if (discard_left_reg != '0) begin
                        discard_left_next = (discard_left_reg > {8'd0, s1_len_reg})
                            ? discard_left_reg - {8'd0, s1_len_reg} : '0;
                        dropping_next = 1'b1;
                    end else begin
                        dropping_next = 1'b0;
                    end
                end
                result_next = !dropping_next;
                if (!dropping_next && nco_enable_reg) begin
                    out_i_next = round15(34'(p_ir) - 34'(p_qi));
                    out_q_next = round15(34'(p_ii) + 34'(p_qr));
                    phase_re_next = round15(34'(p_rc) - 34'(p_is));
                    phase_im_next = round15(34'(p_rs) + 34'(p_ic));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            swap_iq_reg <= 1'b0;
            invert_q_reg <= 1'b0;
            nco_enable_reg <= 1'b0;
            step_cos_reg <= Q15_ONE;
            step_sin_reg <= Q15_ZERO;
            adc_bits_reg <= RST_ADC_BITS;
            discard_count_reg <= RST_DISCARD_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_SWAP_IQ: swap_iq_reg <= cfg_data[0];
                REG_INVERT_Q: invert_q_reg <= cfg_data[0];
                REG_NCO_ENABLE: nco_enable_reg <= cfg_data[0];
                REG_NCO_STEP_COS: step_cos_reg <= cfg_data[15:0];
                REG_NCO_STEP_SIN: step_sin_reg <= cfg_data[15:0];
                REG_ADC_BITS: adc_bits_reg <= cfg_data[4:0];
                REG_DISCARD_COUNT: discard_count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_re_reg <= Q15_ONE;
            phase_im_reg <= Q15_ZERO;
            discard_left_reg <= '0;
            dropping_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= result_next;
                phase_re_reg <= phase_re_next;
                phase_im_reg <= phase_im_next;
                discard_left_reg <= discard_left_next;
                dropping_reg <= dropping_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            s1_action_reg <= action_t'(s_tuser[1:0]);
            s1_start_reg <= s_tuser[2];
            s1_i_reg <= s_tdata[SW-1:0];
            s1_q_reg <= s_tdata[2*SW-1:SW];
            s1_len_reg <= s_tdata[2*SW+15:2*SW];
        end
        if (advance && result_next) begin
            out_i_reg <= out_i_next;
            out_q_reg <= out_q_next;
        end
    end

`ifndef ASSERT_OFF
    a_reset_home: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_action_reg == ACT_STREAM_RESET |=>
            phase_re_reg == Q15_ONE && phase_im_reg == Q15_ZERO && discard_left_reg == '0)
        else $error("stream reset did not return the phasor and counter home");

    a_no_result_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_action_reg != ACT_SAMPLE |=> !out_valid_reg)
        else $error("control word produced a result");

    a_phasor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_action_reg == ACT_SAMPLE && !nco_enable_reg |=>
            $stable(phase_re_reg) && $stable(phase_im_reg))
        else $error("phasor moved while mixing is off");

    a_discard_down: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_action_reg == ACT_RETUNE) |=>
            discard_left_reg <= $past(discard_left_reg))
        else $error("discard counter grew without a retune");
`endif

endmodule
`default_nettype wire

### bench/iq_conditioner_nco_mixer_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// iq_conditioner_nco_mixer_unit_tb
// Self-checking bench for the IQ conditioner and oscillator mixer. A queue of
// words feeds a bursty stream driver, and a bench-side copy of the datapath
// predicts each result. A monitor with its own stall pattern compares every
// result with the oldest prediction. Stimulus starts with a directed set and
// then sends random block traffic with retunes and stream resets under
// several register settings.
// ---------------------------------------------------------------------------
module iq_conditioner_nco_mixer_unit_tb;
    import iqc_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int IN_W = ((2 * SAMPLE_W + 16 + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 1000;
    localparam int WORDS_PER_PHASE = 240;

    typedef struct {
        action_t            act;
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
        logic               blk_start;
        logic [15:0]        blk_len;
    } iq_word_t;

    typedef struct {
        reg_index_t  idx;
        logic [23:0] data;
    } reg_write_t;

    typedef struct {
        logic signed [15:0] out_i;
        logic signed [15:0] out_q;
    } iq_result_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [2:0]      cfg_index = '0;
    logic [23:0]     cfg_data = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [2:0]      s_tuser = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [31:0]     m_tdata;

    iq_word_t   word_queue[$];
    reg_write_t reg_queue[$];
    iq_result_t expected_iq[$];

    // Bench copy of the registers and datapath state.
    logic               cfg_swap_iq = 1'b0;
    logic               cfg_invert_q = 1'b0;
    logic               cfg_nco_en = 1'b0;
    logic signed [15:0] cfg_step_cos = 16'sd32767;
    logic signed [15:0] cfg_step_sin = 16'sd0;
    logic [4:0]         cfg_adc_bits = RST_ADC_BITS;
    logic [23:0]        cfg_discard = RST_DISCARD_COUNT;
    logic signed [15:0] ph_re = 16'sd32767;
    logic signed [15:0] ph_im = 16'sd0;
    logic [23:0]        discard_left = '0;
    logic               dropping = 1'b0;

    int words_queued = 0;
    int words_accepted = 0;
    int regs_queued = 0;
    int regs_accepted = 0;
    int results_seen = 0;
    int words_dropped = 0;
    int settings_used = 0;
    int errors = 0;
    int idle_cycles = 0;

    iq_word_t   drv_word;
    reg_write_t drv_reg;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         stall_left = 0;
    int         cycle_count = 0;

    iq_conditioner_nco_mixer_unit #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] round_q15(input longint p);
        return sat16((p + 16384) >>> 15);
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [15:0] x);
        int     b;
        longint v;
        b = (cfg_adc_bits == 5'd0) ? 1 : int'(cfg_adc_bits);
        v = longint'(x);
        if (b <= 16) return sat16(v <<< (16 - b));
        return sat16((v + (longint'(1) <<< (b - 17))) >>> (b - 16));
    endfunction

    task automatic condition_word(input iq_word_t w);
        logic signed [15:0] si;
        logic signed [15:0] sq;
        logic signed [15:0] t;
        logic signed [15:0] nr;
        logic signed [15:0] ni;
        iq_result_t         res;
        case (w.act)
            ACT_STREAM_RESET: begin
                discard_left = '0;
                dropping = 1'b0;
                ph_re = Q15_ONE;
                ph_im = Q15_ZERO;
            end
            ACT_RETUNE: begin
                discard_left = cfg_discard;
                ph_re = Q15_ONE;
                ph_im = Q15_ZERO;
            end
            ACT_SAMPLE: begin
                if (w.blk_start) begin
                    if (discard_left != '0) begin
                        discard_left = (discard_left > {8'd0, w.blk_len}) ?
                                       discard_left - {8'd0, w.blk_len} : '0;
                        dropping = 1'b1;
                    end else begin
                        dropping = 1'b0;
                    end
                end
                if (dropping) begin
                    words_dropped++;
                end else begin
                    si = to_q15(w.in_i);
                    sq = to_q15(w.in_q);
                    if (cfg_swap_iq) begin
                        t = si;
                        si = sq;
                        sq = t;
                    end
                    if (cfg_invert_q) sq = sat16(-longint'(sq));
                    if (cfg_nco_en) begin
                        t = round_q15(longint'(si) * longint'(ph_re) -
                                      longint'(sq) * longint'(ph_im));
                        sq = round_q15(longint'(si) * longint'(ph_im) +
                                       longint'(sq) * longint'(ph_re));
                        si = t;
                        nr = round_q15(longint'(ph_re) * longint'(cfg_step_cos) -
                                       longint'(ph_im) * longint'(cfg_step_sin));
                        ni = round_q15(longint'(ph_re) * longint'(cfg_step_sin) +
                                       longint'(ph_im) * longint'(cfg_step_cos));
                        ph_re = nr;
                        ph_im = ni;
                    end
                    res.out_i = si;
                    res.out_q = sq;
                    expected_iq.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    task automatic apply_reg_write(input reg_write_t r);
        case (r.idx)
            REG_SWAP_IQ: cfg_swap_iq = r.data[0];
            REG_INVERT_Q: cfg_invert_q = r.data[0];
            REG_NCO_ENABLE: cfg_nco_en = r.data[0];
            REG_NCO_STEP_COS: cfg_step_cos = r.data[15:0];
            REG_NCO_STEP_SIN: cfg_step_sin = r.data[15:0];
            REG_ADC_BITS: cfg_adc_bits = r.data[4:0];
            REG_DISCARD_COUNT: cfg_discard = r.data;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", results_seen, msg);
        errors++;
    endtask

    // Stream driver: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                condition_word(drv_word);
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0 || word_queue.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    drv_word = word_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= IN_W'({drv_word.blk_len, drv_word.in_q, drv_word.in_i});
                    s_tuser <= {drv_word.blk_start, drv_word.act};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Register write driver.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg_write(drv_reg);
                regs_accepted++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_queue.size() != 0) begin
                    drv_reg = reg_queue.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= drv_reg.idx;
                    cfg_data <= drv_reg.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own stall pattern.
    always @(posedge clk) begin
        iq_result_t want;
        logic       ready;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_iq.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_tdata));
                end else begin
                    want = expected_iq.pop_front();
                    if ($signed(m_tdata[15:0]) != want.out_i)
                        report_mismatch($sformatf("out_i got %0d, expected %0d",
                                                  $signed(m_tdata[15:0]), want.out_i));
                    if ($signed(m_tdata[31:16]) != want.out_q)
                        report_mismatch($sformatf("out_q got %0d, expected %0d",
                                                  $signed(m_tdata[31:16]), want.out_q));
                end
                results_seen++;
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end else begin
                stall_left--;
            end
            cycle_count++;
            case (stall_mode)
                0: ready = 1'b1;
                1: ready = ($urandom_range(0, 2) != 0);
                2: ready = (cycle_count % 3 != 0);
                default: ready = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= ready;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic push_word(input action_t act, input logic signed [15:0] in_i,
                             input logic signed [15:0] in_q, input logic blk_start,
                             input logic [15:0] blk_len);
        iq_word_t w;
        w.act = act;
        w.in_i = in_i;
        w.in_q = in_q;
        w.blk_start = blk_start;
        w.blk_len = blk_len;
        word_queue.push_back(w);
        words_queued++;
    endtask

    task automatic push_reg(input reg_index_t idx, input logic [23:0] data);
        reg_write_t r;
        r.idx = idx;
        r.data = data;
        reg_queue.push_back(r);
        regs_queued++;
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_iq.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input bit sw, input bit inv, input bit en, input int sc,
                              input int ss, input int bits, input int dc);
        push_reg(REG_SWAP_IQ, {23'd0, sw});
        push_reg(REG_INVERT_Q, {23'd0, inv});
        push_reg(REG_NCO_ENABLE, {23'd0, en});
        push_reg(REG_NCO_STEP_COS, {8'd0, 16'(sc)});
        push_reg(REG_NCO_STEP_SIN, {8'd0, 16'(ss)});
        push_reg(REG_ADC_BITS, {19'd0, 5'(bits)});
        push_reg(REG_DISCARD_COUNT, 24'(dc));
        while (regs_accepted != regs_queued) @(posedge clk);
        settings_used++;
    endtask

    function automatic logic signed [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        if (r < 5) return 16'(int'($urandom_range(0, 4095)) - 2048);
        return 16'($urandom);
    endfunction

    // Well-formed blocks with random content, mixed with retunes, stream resets,
    // unused action codes and the odd block with a bogus length.
    task automatic random_traffic(input int n);
        int made;
        int r;
        int blen;
        int k;
        logic [15:0] len_field;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                push_word(ACT_RETUNE, rand_sample(), rand_sample(), 1'($urandom), 16'($urandom));
                made++;
            end else if (r < 14) begin
                push_word(ACT_STREAM_RESET, rand_sample(), rand_sample(), 1'($urandom),
                          16'($urandom));
                made++;
            end else if (r < 17) begin
                push_word(ACT_UNUSED, rand_sample(), rand_sample(), 1'($urandom),
                          16'($urandom));
            end else begin
                blen = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) :
                       $urandom_range(1, 10);
                len_field = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(blen);
                for (k = 0; k < blen; k++) begin
                    if (k == 0)
                        push_word(ACT_SAMPLE, rand_sample(), rand_sample(),
                                  ($urandom_range(0, 19) != 0), len_field);
                    else
                        push_word(ACT_SAMPLE, rand_sample(), rand_sample(), 1'b0,
                                  16'($urandom));
                end
                made += blen;
            end
        end
    endtask

    initial begin
        int  p;
        real ang;
        int  sc;
        int  ss;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: no mixing, 12-bit converter, large discard count.
        push_word(ACT_SAMPLE, 16'sh7fff, 16'sh8000, 1'b1, 16'd1);
        push_word(ACT_SAMPLE, 16'sd2047, -16'sd2048, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, -16'sd1, 16'sd1, 1'b0, 16'hffff);
        push_word(ACT_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'd0);
        push_word(ACT_UNUSED, 16'sh5a5a, 16'sha5a5, 1'b1, 16'd0);
        push_word(ACT_RETUNE, 16'sd0, 16'sd0, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, 16'sd100, -16'sd100, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, 16'sd5, 16'sd5, 1'b1, 16'hffff);
        push_word(ACT_SAMPLE, 16'sd6, 16'sd6, 1'b0, 16'd0);
        push_word(ACT_STREAM_RESET, 16'sd0, 16'sd0, 1'b1, 16'd3);
        push_word(ACT_SAMPLE, 16'sh8000, 16'sh7fff, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, 16'sd1000, -16'sd1000, 1'b1, 16'd7);
        wait_idle();

        // Swap, negate and mix with the most negative step; a short discard.
        set_config(1'b1, 1'b1, 1'b1, -32768, -32768, 16, 3);
        push_word(ACT_SAMPLE, 16'sh8000, 16'sh8000, 1'b1, 16'd1);
        push_word(ACT_SAMPLE, 16'sh7fff, 16'sh7fff, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, 16'sd12345, -16'sd23456, 1'b0, 16'd0);
        push_word(ACT_RETUNE, 16'sd0, 16'sd0, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, 16'sd1, 16'sd2, 1'b1, 16'd2);
        push_word(ACT_SAMPLE, 16'sd3, 16'sd4, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, 16'sd5, 16'sd6, 1'b1, 16'd0);
        push_word(ACT_SAMPLE, 16'sd7, 16'sd8, 1'b1, 16'hffff);
        push_word(ACT_SAMPLE, -16'sd1, 16'sd1, 1'b1, 16'd1);
        push_word(ACT_SAMPLE, 16'sh7fff, 16'sh8000, 1'b0, 16'd0);
        push_word(ACT_UNUSED, 16'sd0, 16'sd0, 1'b0, 16'd0);
        push_word(ACT_STREAM_RESET, 16'sd0, 16'sd0, 1'b0, 16'd0);
        push_word(ACT_SAMPLE, 16'sd321, -16'sd321, 1'b0, 16'd0);
        wait_idle();

        for (p = 0; p < 8; p++) begin
            ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            sc = $rtoi(32767.0 * $cos(ang));
            ss = $rtoi(32767.0 * $sin(ang));
            case (p)
                0: set_config(1'b0, 1'b1, 1'b1, 32767, 0, 12, 20);
                1: set_config(1'b1, 1'b0, 1'b1, sc, ss, 16, 5);
                2: set_config(1'b1, 1'b1, 1'b1, -32768, -32768, 8, 0);
                3: set_config(1'b0, 1'b0, 1'b0, 0, 32767, 16, 16777215);
                4: set_config(1'b1, 1'b1, 1'b1, 32767, 32767, 0, 30);
                5: set_config(1'b0, 1'b1, 1'b1, sc, ss, 31, 12);
                6: set_config(1'b1, 1'b0, 1'b1, sc, ss, 17, 3);
                default: set_config(1'($urandom), 1'($urandom), 1'($urandom),
                                    int'(16'($urandom)) - 32768, int'(16'($urandom)) - 32768,
                                    $urandom_range(8, 16), $urandom_range(0, 40));
            endcase
            random_traffic(WORDS_PER_PHASE);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d words under %0d register settings (%0d register writes).",
                  words_accepted, settings_used, regs_accepted);
        $display("Checked %0d results; %0d samples fell in dropped blocks; %0d mismatches.",
                  results_seen, words_dropped, errors);
        if (errors == 0 && expected_iq.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### iq_conditioner_nco_mixer_unit.f
hw/rtl/iqc_pkg.sv
hw/rtl/iq_conditioner_nco_mixer_unit.sv
bench/iq_conditioner_nco_mixer_unit_tb.sv
